// ===== rtl/interval_list_boolean_merge_assert.svh =====
// Assertion macros used by the RTL of the interval list merge.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef INTERVAL_LIST_BOOLEAN_MERGE_ASSERT_SVH
`define INTERVAL_LIST_BOOLEAN_MERGE_ASSERT_SVH

`define ILBM_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

`define ILBM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

`define ILBM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/ilbm_pkg.sv =====
`timescale 1ns / 1ps

package ilbm_pkg;

    localparam int MAX_RESULTS = 32;
    localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);
    localparam logic [RES_CNT_W-1:0] RESULT_LIMIT = RES_CNT_W'(MAX_RESULTS);

    localparam logic [1:0] KIND_LOAD_A = 2'd0;
    localparam logic [1:0] KIND_LOAD_B = 2'd1;
    localparam logic [1:0] KIND_RUN    = 2'd2;

    localparam logic [1:0] OP_UNION     = 2'd0;
    localparam logic [1:0] OP_INTERSECT = 2'd1;
    localparam logic [1:0] OP_SUBTRACT  = 2'd2;

    typedef struct packed {
        logic [1:0]         code;
        logic signed [31:0] position;
    } t_cmd;

    typedef struct packed {
        logic signed [31:0] position;
        logic               flipped;
        logic               empty_marker;
        logic               overflowed;
        logic               last;
    } t_result;

endpackage

// ===== rtl/interval_list_boolean_merge.sv =====
`timescale 1ns / 1ps
// Interval list boolean merge.
// Input channel (i_in_valid / o_in_stall) carries a kind and a Q23.8 position.
// Kind load A or load B appends the position to that list; a load into a full
// list is dropped and flagged. Kind run merges both lists and streams the
// crossings of the combined set on the output channel (o_out_valid /
// i_out_stall); the final transaction of a run has o_last set, and a run
// with no crossing gives one transaction with o_empty_marker set.
// The operation register (APB, address 0) selects union, intersection or
// subtraction of B from A; the user must write it only while the block is
// idle, which the block itself does not enforce. Loads are handled while
// the back end is idle. During a run it consumes one stored element per
// cycle while the output register is free, holds while that is full and
// stalled, and ends early at the result limit. A crossing is presented in
// the cycle after the next crossing is found; after the last element the
// run passes to the finish state, which registers the final transaction.
// A two-entry command queue lets new items be taken while a run proceeds.
// On a receiver stall the back end holds, the queue fills and o_in_stall rises.
// Reset clears both lists, the overflow flag, the queue and the operation.
module interval_list_boolean_merge
    import ilbm_pkg::*;
#(
    parameter int MAX_CROSSINGS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_kind,
    input  logic signed [31:0] i_position,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_out_position,
    output logic               o_flipped,
    output logic               o_empty_marker,
    output logic               o_overflowed,
    output logic               o_last,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [1:0] r_op;
    logic       cfg_wr;
    t_cmd       cmd;
    logic       cmd_valid;
    logic       cmd_pop;
    t_result    res;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && !paddr[2];
    assign prdata = paddr[2] ? 32'd0 : {30'd0, r_op};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op <= OP_UNION;
        end else if (cfg_wr) begin
            r_op <= pwdata[1:0];
        end
    end

    ilbm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_kind      (i_kind),
        .i_position  (i_position),
        .o_in_stall  (o_in_stall),
        .o_cmd       (cmd),
        .o_cmd_valid (cmd_valid),
        .i_cmd_pop   (cmd_pop)
    );

    ilbm_back #(
        .MAX_CROSSINGS (MAX_CROSSINGS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cmd_valid (cmd_valid),
        .o_cmd_pop   (cmd_pop),
        .i_op        (r_op),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out       (res)
    );

    assign o_out_position = res.position;
    assign o_flipped      = res.flipped;
    assign o_empty_marker = res.empty_marker;
    assign o_overflowed   = res.overflowed;
    assign o_last         = res.last;

endmodule

// ===== rtl/ilbm_front.sv =====
`timescale 1ns / 1ps

module ilbm_front
    import ilbm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic [1:0]         i_kind,
    input  logic signed [31:0] i_position,
    output logic               o_in_stall,
    output t_cmd               o_cmd,
    output logic               o_cmd_valid,
    input  logic               i_cmd_pop
);

    localparam int Q_DEPTH = 2;
    localparam int PTR_W   = $clog2(Q_DEPTH);
    localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

    t_cmd              r_q [Q_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_cnt, n_cnt;
    logic              full;
    logic              accept;
    logic              keep;
    logic              push;

    // Unused kind codes are accepted and dropped here.
    always_comb begin
        unique case (i_kind) inside
            KIND_LOAD_A, KIND_LOAD_B, KIND_RUN: keep = 1'b1;
            default:                            keep = 1'b0;
        endcase
    end

    assign full        = (r_cnt == QCNT_W'(Q_DEPTH));
    assign o_in_stall  = full;
    assign accept      = i_in_valid && !full;
    assign push        = accept && keep;
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rd_ptr];

    always_comb begin
        n_wr_ptr = push ? r_wr_ptr + PTR_W'(1) : r_wr_ptr;
        n_rd_ptr = i_cmd_pop ? r_rd_ptr + PTR_W'(1) : r_rd_ptr;
        n_cnt    = r_cnt + QCNT_W'(push) - QCNT_W'(i_cmd_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= '{code: i_kind, position: i_position};
        end
    end

endmodule

// ===== rtl/ilbm_back.sv =====
`timescale 1ns / 1ps

`include "interval_list_boolean_merge_assert.svh"

module ilbm_back
    import ilbm_pkg::*;
#(
    parameter int MAX_CROSSINGS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    input  logic       i_cmd_valid,
    output logic       o_cmd_pop,
    input  logic [1:0] i_op,
    input  logic       i_out_stall,
    output logic       o_out_valid,
    output t_result    o_out
);

    localparam int CNT_W = $clog2(MAX_CROSSINGS + 1);
    localparam int ADR_W = $clog2(MAX_CROSSINGS);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_CROSSINGS);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    function automatic logic combine(input logic [1:0] op, input logic in_a,
                                     input logic in_b);
        logic res;
        case (op)
            OP_INTERSECT: res = in_a && in_b;
            OP_SUBTRACT:  res = in_a && !in_b;
            default:      res = in_a || in_b;
        endcase
        return res;
    endfunction

    logic [31:0] mem_a [MAX_CROSSINGS];
    logic [31:0] mem_b [MAX_CROSSINGS];
    logic signed [31:0] r_rd_a, r_rd_b;

    logic [1:0]           r_state, n_state;
    logic [CNT_W-1:0]     r_cnt_a, n_cnt_a;
    logic [CNT_W-1:0]     r_cnt_b, n_cnt_b;
    logic                 r_ovf, n_ovf;
    logic [CNT_W-1:0]     r_i, n_i;
    logic [CNT_W-1:0]     r_j, n_j;
    logic [RES_CNT_W-1:0] r_n, n_n;
    logic                 r_pend_valid, n_pend_valid;
    logic signed [31:0]   r_pend_pos, n_pend_pos;
    logic                 r_pend_flip, n_pend_flip;
    logic                 r_out_valid, n_out_valid;
    t_result              r_out, n_out;

    logic out_free;
    logic pop;
    logic we_a, we_b;
    logic a_left, b_left;
    logic take_a;
    logic was_in, now_in;
    logic run_done;

    assign out_free = !r_out_valid || !i_out_stall;
    assign pop      = (r_state == ST_IDLE) && i_cmd_valid;
    assign a_left   = (r_i < r_cnt_a);
    assign b_left   = (r_j < r_cnt_b);
    assign take_a   = !b_left ? 1'b1 : (!a_left ? 1'b0 : (r_rd_a < r_rd_b));
    assign was_in   = combine(i_op, r_i[0], r_j[0]);
    assign now_in   = combine(i_op, r_i[0] ^ take_a, r_j[0] ^ !take_a);
    assign run_done = (!a_left && !b_left) || (r_n == RESULT_LIMIT);

    always_comb begin
        n_state      = r_state;
        n_cnt_a      = r_cnt_a;
        n_cnt_b      = r_cnt_b;
        n_ovf        = r_ovf;
        n_i          = r_i;
        n_j          = r_j;
        n_n          = r_n;
        n_pend_valid = r_pend_valid;
        n_pend_pos   = r_pend_pos;
        n_pend_flip  = r_pend_flip;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out        = r_out;
        we_a         = 1'b0;
        we_b         = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (pop) begin
                    case (i_cmd.code)
                        KIND_LOAD_A: begin
                            if (r_cnt_a < CNT_MAX) begin
                                we_a    = 1'b1;
                                n_cnt_a = r_cnt_a + CNT_W'(1);
                            end else begin
                                n_ovf = 1'b1;
                            end
                        end
                        KIND_LOAD_B: begin
                            if (r_cnt_b < CNT_MAX) begin
                                we_b    = 1'b1;
                                n_cnt_b = r_cnt_b + CNT_W'(1);
                            end else begin
                                n_ovf = 1'b1;
                            end
                        end
                        default: begin
                            n_i          = '0;
                            n_j          = '0;
                            n_n          = '0;
                            n_pend_valid = 1'b0;
                            n_state      = ST_RUN;
                        end
                    endcase
                end
            end
            ST_RUN: begin
                if (out_free) begin
                    if (run_done) begin
                        n_state = ST_FIN;
                    end else begin
                        if (take_a) begin
                            n_i = r_i + CNT_W'(1);
                        end else begin
                            n_j = r_j + CNT_W'(1);
                        end
                        if (was_in != now_in) begin
                            n_n          = r_n + RES_CNT_W'(1);
                            n_pend_valid = 1'b1;
                            n_pend_pos   = take_a ? r_rd_a : r_rd_b;
                            n_pend_flip  = !take_a && (i_op == OP_SUBTRACT);
                            if (r_pend_valid) begin
                                n_out_valid = 1'b1;
                                n_out       = '{position: r_pend_pos,
                                                flipped: r_pend_flip,
                                                empty_marker: 1'b0,
                                                overflowed: r_ovf,
                                                last: 1'b0};
                            end
                        end
                    end
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = '{position: r_pend_valid ? r_pend_pos : 32'sd0,
                                    flipped: r_pend_valid && r_pend_flip,
                                    empty_marker: !r_pend_valid,
                                    overflowed: r_ovf,
                                    last: 1'b1};
                    n_cnt_a      = '0;
                    n_cnt_b      = '0;
                    n_ovf        = 1'b0;
                    n_pend_valid = 1'b0;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_cnt_a      <= '0;
            r_cnt_b      <= '0;
            r_ovf        <= 1'b0;
            r_i          <= '0;
            r_j          <= '0;
            r_n          <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cnt_a      <= n_cnt_a;
            r_cnt_b      <= n_cnt_b;
            r_ovf        <= n_ovf;
            r_i          <= n_i;
            r_j          <= n_j;
            r_n          <= n_n;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_pos  <= n_pend_pos;
        r_pend_flip <= n_pend_flip;
        r_out       <= n_out;
    end

    // The read address is the next head index, so the read data always
    // holds the current head of each list.
    always_ff @(posedge i_clk) begin
        if (we_a) begin
            mem_a[r_cnt_a[ADR_W-1:0]] <= i_cmd.position;
        end
        r_rd_a <= mem_a[n_i[ADR_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (we_b) begin
            mem_b[r_cnt_b[ADR_W-1:0]] <= i_cmd.position;
        end
        r_rd_b <= mem_b[n_j[ADR_W-1:0]];
    end

    assign o_cmd_pop   = pop;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    `ILBM_ASSERT_ALWAYS(a_cnt_range, (r_cnt_a <= CNT_MAX) && (r_cnt_b <= CNT_MAX), "list count beyond capacity")
    `ILBM_ASSERT_ALWAYS(a_res_range, r_n <= RESULT_LIMIT, "result count beyond limit")
    `ILBM_ASSERT_IMP(a_empty_last, r_out_valid && r_out.empty_marker, r_out.last && !r_out.flipped, "empty marker without last")
    `ILBM_ASSERT_NEXT(a_fin_clear, (r_state == ST_FIN) && out_free, (r_cnt_a == '0) && (r_cnt_b == '0) && !r_ovf && (r_state == ST_IDLE), "run end did not clear lists")

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import ilbm_pkg::*;

    localparam int CAP = 16;
    localparam int PHASES = 7;
    localparam int ITEMS_PER_PHASE = 56;
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [2:0] REG_OPERATION = 3'd0;
    localparam logic signed [31:0] POS_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] POS_MAX = 32'sh7fff_ffff;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [1:0]         i_kind = KIND_LOAD_A;
    logic signed [31:0] i_position = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic signed [31:0] o_out_position;
    logic               o_flipped;
    logic               o_empty_marker;
    logic               o_overflowed;
    logic               o_last;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    interval_list_boolean_merge #(
        .MAX_CROSSINGS(CAP)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_kind         (i_kind),
        .i_position     (i_position),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_position (o_out_position),
        .o_flipped      (o_flipped),
        .o_empty_marker (o_empty_marker),
        .o_overflowed   (o_overflowed),
        .o_last         (o_last),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Mirror of the block state used to predict the crossings.
    logic signed [31:0] list_a [CAP];
    logic signed [31:0] list_b [CAP];
    int                 fill_a = 0;
    int                 fill_b = 0;
    logic               dropped_load = 1'b0;
    logic [1:0]         op_model = OP_UNION;

    t_cmd    cmd_backlog [$];
    t_result crossings_due [$];
    t_cmd    next_cmd;

    int   errors = 0;
    int   planned = 0;
    int   items_taken = 0;
    int   merges_done = 0;
    int   results_checked = 0;
    logic in_fire = 1'b0;
    logic calm = 1'b0;
    logic hold_req = 1'b0;
    logic long_hold = 1'b0;
    int   send_gap = 0;
    int   send_quiet = 0;
    int   recv_gap = 0;
    int   recv_quiet = 0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH at %0t: %s, got %h, expected %h", $realtime, what, got, want);
        errors++;
    endtask

    function automatic logic combined_inside(input logic in_a, input logic in_b);
        case (op_model)
            OP_INTERSECT: return in_a && in_b;
            OP_SUBTRACT:  return in_a && !in_b;
            default:      return in_a || in_b;
        endcase
    endfunction

    task automatic predict_crossings();
        int      ia;
        int      ib;
        int      found;
        logic    take_a;
        logic    was_in;
        logic    now_in;
        t_result held;
        ia = 0;
        ib = 0;
        found = 0;
        held = '0;
        while ((ia < fill_a || ib < fill_b) && found < MAX_RESULTS) begin
            if (ib >= fill_b)
                take_a = 1'b1;
            else if (ia >= fill_a)
                take_a = 1'b0;
            else
                take_a = list_a[ia] < list_b[ib];
            was_in = combined_inside(ia[0], ib[0]);
            if (take_a)
                ia++;
            else
                ib++;
            now_in = combined_inside(ia[0], ib[0]);
            if (was_in != now_in) begin
                if (found > 0)
                    crossings_due.insert(crossings_due.size(), held);
                held.position = take_a ? list_a[ia - 1] : list_b[ib - 1];
                held.flipped = !take_a && op_model == OP_SUBTRACT;
                held.empty_marker = 1'b0;
                held.overflowed = dropped_load;
                held.last = 1'b0;
                found++;
            end
        end
        if (found == 0) begin
            held.position = '0;
            held.flipped = 1'b0;
            held.empty_marker = 1'b1;
            held.overflowed = dropped_load;
        end
        held.last = 1'b1;
        crossings_due.insert(crossings_due.size(), held);
        fill_a = 0;
        fill_b = 0;
        dropped_load = 1'b0;
        merges_done++;
    endtask

    task automatic apply_command(input logic [1:0] code, input logic signed [31:0] pos);
        case (code)
            KIND_LOAD_A: begin
                if (fill_a < CAP) begin
                    list_a[fill_a] = pos;
                    fill_a++;
                end else begin
                    dropped_load = 1'b1;
                end
                items_taken++;
            end
            KIND_LOAD_B: begin
                if (fill_b < CAP) begin
                    list_b[fill_b] = pos;
                    fill_b++;
                end else begin
                    dropped_load = 1'b1;
                end
                items_taken++;
            end
            KIND_RUN: begin
                predict_crossings();
                items_taken++;
            end
            default: ;
        endcase
    endtask

    task automatic check_result();
        t_result want;
        if (crossings_due.size() == 0) begin
            report_mismatch("transaction with nothing expected", o_out_position, '0);
        end else begin
            want = crossings_due.pop_front();
            if (o_out_position !== want.position)
                report_mismatch("out_position", o_out_position, want.position);
            if (o_flipped !== want.flipped)
                report_mismatch("flipped", o_flipped, want.flipped);
            if (o_empty_marker !== want.empty_marker)
                report_mismatch("empty_marker", o_empty_marker, want.empty_marker);
            if (o_overflowed !== want.overflowed)
                report_mismatch("overflowed", o_overflowed, want.overflowed);
            if (o_last !== want.last)
                report_mismatch("last", o_last, want.last);
            results_checked++;
        end
    endtask

    always @(posedge i_clk) begin
        in_fire <= i_in_valid && !o_in_stall;
        if (i_rst_n && i_in_valid && !o_in_stall)
            apply_command(i_kind, i_position);
        if (i_rst_n && o_out_valid && !i_out_stall)
            check_result();
    end

    function automatic logic idle_roll(inout int gap, inout int quiet);
        int pick;
        if (calm)
            return 1'b0;
        if (gap > 0) begin
            gap--;
            return 1'b1;
        end
        if (quiet > 0) begin
            quiet--;
            return 1'b0;
        end
        pick = $urandom_range(0, 9);
        if (pick < 3) begin
            gap = $urandom_range(0, 5);
            return 1'b1;
        end
        if (pick == 3)
            quiet = $urandom_range(10, 40);
        return 1'b0;
    endfunction

    always @(negedge i_clk) begin
        if (!i_in_valid || in_fire) begin
            if (cmd_backlog.size() == 0 || idle_roll(send_gap, send_quiet)) begin
                i_in_valid <= 1'b0;
            end else begin
                next_cmd = cmd_backlog.pop_front();
                i_in_valid <= 1'b1;
                i_kind <= next_cmd.code;
                i_position <= next_cmd.position;
            end
        end
    end

    always @(negedge i_clk) begin
        i_out_stall <= long_hold || idle_roll(recv_gap, recv_quiet);
    end

    initial begin
        wait (hold_req);
        @(negedge i_clk);
        long_hold <= 1'b1;
        repeat (300) @(negedge i_clk);
        long_hold <= 1'b0;
    end

    task automatic push_cmd(input logic [1:0] code, input logic signed [31:0] pos);
        t_cmd c;
        c.code = code;
        c.position = pos;
        cmd_backlog.insert(cmd_backlog.size(), c);
        if (code != KIND_UNUSED)
            planned++;
    endtask

    function automatic logic signed [31:0] pick_position();
        case ($urandom_range(0, 3))
            0, 1: return $urandom;
            2: return 32'sd256 * ($signed($urandom_range(0, 4)) - 2);
            default: begin
                case ($urandom_range(0, 3))
                    0: return POS_MIN;
                    1: return POS_MAX;
                    2: return '0;
                    default: return -32'sd1;
                endcase
            end
        endcase
    endfunction

    task automatic build_list(input int n, input bit ordered, ref int ends[$]);
        int v;
        int k;
        ends.delete();
        repeat (n) begin
            v = pick_position();
            k = ends.size();
            if (ordered)
                while (k > 0 && ends[k - 1] > v)
                    k--;
            ends.insert(k, v);
        end
    endtask

    task automatic queue_merge_set(input int na, input int nb, input bit ordered);
        int ends_a [$];
        int ends_b [$];
        int ia;
        int ib;
        build_list(na, ordered, ends_a);
        build_list(nb, ordered, ends_b);
        ia = 0;
        ib = 0;
        while (ia < na || ib < nb) begin
            if ($urandom_range(0, 19) == 0)
                push_cmd(KIND_UNUSED, $urandom);
            if (ib >= nb || (ia < na && $urandom_range(0, 1) == 1)) begin
                push_cmd(KIND_LOAD_A, ends_a[ia]);
                ia++;
            end else begin
                push_cmd(KIND_LOAD_B, ends_b[ib]);
                ib++;
            end
        end
        push_cmd(KIND_RUN, $urandom);
    endtask

    task automatic set_operation(input logic [1:0] value);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= REG_OPERATION;
        pwdata <= {30'd0, value};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        op_model = value;
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        if (prdata !== {30'd0, value})
            report_mismatch("operation readback", prdata, {30'd0, value});
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic settle();
        wait (cmd_backlog.size() == 0 && !i_in_valid && crossings_due.size() == 0);
        repeat (12) @(negedge i_clk);
    endtask

    function automatic logic [1:0] phase_operation(input int phase);
        case (phase)
            0: return OP_INTERSECT;
            1: return OP_SUBTRACT;
            2: return OP_UNUSED;
            3: return OP_UNION;
            4: return OP_SUBTRACT;
            5: return OP_INTERSECT;
            default: return OP_UNION;
        endcase
    endfunction

    initial begin
        int phase;
        int phase_start;
        int pick;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Both lists empty, then a tie at POS_MIN with B taken first.
        push_cmd(KIND_RUN, POS_MAX);
        push_cmd(KIND_LOAD_A, POS_MIN);
        push_cmd(KIND_LOAD_A, POS_MAX);
        push_cmd(KIND_LOAD_B, POS_MIN);
        push_cmd(KIND_LOAD_B, '0);
        push_cmd(KIND_RUN, '0);
        push_cmd(KIND_UNUSED, POS_MAX);
        push_cmd(KIND_LOAD_A, 32'sd1280);
        push_cmd(KIND_LOAD_A, 32'sd1280);
        push_cmd(KIND_LOAD_B, -32'sd1);
        push_cmd(KIND_LOAD_B, 32'sd512);
        push_cmd(KIND_RUN, POS_MIN);
        push_cmd(KIND_LOAD_B, -32'sd256);
        push_cmd(KIND_LOAD_B, 32'sd256);
        push_cmd(KIND_RUN, -32'sd1);
        settle();

        for (phase = 0; phase < PHASES; phase++) begin
            if (phase == PHASES - 1)
                calm = 1'b1;
            set_operation(phase_operation(phase));
            phase_start = planned;
            while (planned - phase_start < ITEMS_PER_PHASE) begin
                pick = $urandom_range(0, 19);
                if (pick == 0) begin
                    if ($urandom_range(0, 1))
                        queue_merge_set($urandom_range(17, 19), $urandom_range(0, 4), 1'b1);
                    else
                        queue_merge_set($urandom_range(0, 4), $urandom_range(17, 19), 1'b1);
                end else if (pick < 4) begin
                    queue_merge_set($urandom_range(7, 16), $urandom_range(7, 16), 1'b1);
                end else if (pick == 4) begin
                    queue_merge_set($urandom_range(0, 8), $urandom_range(0, 8), 1'b0);
                end else begin
                    queue_merge_set($urandom_range(0, 6), $urandom_range(0, 6), 1'b1);
                end
            end
            if (phase == 2)
                hold_req = 1'b1;
            settle();
        end

        repeat (20) @(negedge i_clk);
        $display("Covered %0d transactions in, %0d merges and %0d checked results out,",
                 items_taken, merges_done, results_checked);
        $display("across all operation codes, full lists, ties and a long output stall.");
        if (errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Timed out with %0d results still expected.", crossings_due.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/ilbm_pkg.sv
rtl/ilbm_front.sv
rtl/ilbm_back.sv
rtl/interval_list_boolean_merge.sv
tb/testbench.sv
